>>> design/kst_pkg.sv
// ----------------------------------------------------------------------------
// kst_pkg: shared types and constants for the keyed slot table
// Request codes, internal command and sequencer types, port payload structs.
// ----------------------------------------------------------------------------
package kst_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SLOT_W  = 5;
  localparam int KEY_W   = 32;
  localparam int PAY_W   = 16;
  localparam int REQ_W   = 3;

  localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FIRST  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_NEXT   = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_LOOKUP,
    OP_DELETE,
    OP_FIRST,
    OP_NEXT,
    OP_BAD
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CMP,
    B_ENC,
    B_RD
  } bst_t;

  typedef struct packed {
    logic [REQ_W-1:0]        req_type;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload_handle;
  } in_t;

  typedef struct packed {
    logic                    status;
    logic [SLOT_W-1:0]       slot_index;
    logic signed [KEY_W-1:0] found_key;
    logic [PAY_W-1:0]        found_payload;
  } out_t;

  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        pay;
  } cmd_t;

endpackage

>>> design/kst_ram.sv
// ----------------------------------------------------------------------------
// kst_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kst_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/kst_front.sv
// ----------------------------------------------------------------------------
// kst_front: request intake
// Decodes the request type into a command and holds it in a two-entry queue.
// ----------------------------------------------------------------------------
module kst_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  kst_pkg::in_t  in_data,
  output logic          cmd_valid,
  input  logic          cmd_pop,
  output kst_pkg::cmd_t cmd_data
);
  import kst_pkg::*;

  cmd_t       mem_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       push_ok;
  logic       pop_ok;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.key = in_data.key;
    cmd_in.pay = in_data.payload_handle;
    case (in_data.req_type)
      REQ_ADD:    cmd_in.op = OP_ADD;
      REQ_LOOKUP: cmd_in.op = OP_LOOKUP;
      REQ_DELETE: cmd_in.op = OP_DELETE;
      REQ_FIRST:  cmd_in.op = OP_FIRST;
      REQ_NEXT:   cmd_in.op = OP_NEXT;
      default:    cmd_in.op = OP_BAD;
    endcase
  end

  assign full      = (count_r == 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd_data  = mem_r[rd_ptr_r];
  assign push_ok   = push && !full;
  assign pop_ok    = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push_ok ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

>>> design/kst_outq.sv
// ----------------------------------------------------------------------------
// kst_outq: result queue
// Two-entry queue between the table sequencer and the result port.
// ----------------------------------------------------------------------------
module kst_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_push,
  input  kst_pkg::out_t res_data,
  output logic          res_room,
  output logic          empty,
  input  logic          pop,
  output kst_pkg::out_t out_data
);
  import kst_pkg::*;

  out_t       mem_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic       push_ok;
  logic       pop_ok;

  assign empty    = (count_r == 2'd0);
  assign res_room = (count_r != 2'd2);
  assign out_data = mem_r[rd_ptr_r];
  assign push_ok  = res_push && res_room;
  assign pop_ok   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = push_ok ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= res_data;
    end
  end

endmodule

>>> design/kst_back.sv
// ----------------------------------------------------------------------------
// kst_back: slot table and request sequencer
// Compares all keys in parallel, priority-encodes the registered selection
// vector, updates table and cursor, and reads the payload RAM for reports.
// ----------------------------------------------------------------------------
module kst_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  input  kst_pkg::cmd_t cmd_data,
  input  logic          res_room,
  output logic          res_push,
  output kst_pkg::out_t res_data
);
  import kst_pkg::*;

  bst_t                    state_r, state_nxt;
  cmd_t                    op_r, op_nxt;
  logic [ENTRIES-1:0]      sel_r, sel_nxt;
  logic                    dup_r, dup_nxt;
  logic [IDX_W-1:0]        hit_r, hit_nxt;
  logic [ENTRIES-1:0]      valid_r, valid_nxt;
  logic signed [KEY_W-1:0] keys_r [ENTRIES];
  logic                    cursor_set_r, cursor_set_nxt;
  logic [IDX_W-1:0]        cursor_r, cursor_nxt;

  logic [ENTRIES-1:0]      match_vec;
  logic [ENTRIES-1:0]      walk_vec;
  logic                    use_cur;
  logic [IDX_W-1:0]        enc_hit;
  logic                    enc_found;
  logic                    enc_report;
  logic                    key_we;
  logic                    ram_we;
  logic                    ram_re;
  logic [PAY_W-1:0]        ram_rdata;

  // parallel key compare and cursor walk mask
  assign use_cur = (op_r.op == OP_NEXT) && cursor_set_r;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i] = valid_r[i] && (keys_r[i] == op_r.key);
      walk_vec[i]  = valid_r[i] && (!use_cur || (IDX_W'(i) > cursor_r));
    end
  end

  // lowest set bit of the registered selection
  always_comb begin
    enc_hit = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (sel_r[i]) begin
        enc_hit = IDX_W'(i);
      end
    end
    enc_found  = |sel_r;
    enc_report = enc_found &&
                 ((op_r.op == OP_LOOKUP) || (op_r.op == OP_FIRST) || (op_r.op == OP_NEXT));
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid && res_room) begin
          state_nxt = B_CMP;
        end
      end
      B_CMP: state_nxt = B_ENC;
      B_ENC: state_nxt = enc_report ? B_RD : B_IDLE;
      B_RD:  state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop        = 1'b0;
    op_nxt         = op_r;
    sel_nxt        = sel_r;
    dup_nxt        = dup_r;
    hit_nxt        = hit_r;
    valid_nxt      = valid_r;
    cursor_set_nxt = cursor_set_r;
    cursor_nxt     = cursor_r;
    key_we         = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    res_push       = 1'b0;
    res_data       = '0;
    res_data.status = 1'b1;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid && res_room) begin
          cmd_pop = 1'b1;
          op_nxt  = cmd_data;
        end
      end
      B_CMP: begin
        dup_nxt = |match_vec;
        case (op_r.op)
          OP_ADD:                sel_nxt = ~valid_r;
          OP_LOOKUP, OP_DELETE:  sel_nxt = match_vec;
          OP_FIRST, OP_NEXT:     sel_nxt = walk_vec;
          default:               sel_nxt = '0;
        endcase
      end
      B_ENC: begin
        hit_nxt = enc_hit;
        case (op_r.op)
          OP_ADD: begin
            if (enc_found && !dup_r) begin
              valid_nxt[enc_hit]  = 1'b1;
              key_we              = 1'b1;
              ram_we              = 1'b1;
              res_data.status     = 1'b0;
              res_data.slot_index = SLOT_W'(enc_hit);
            end
          end
          OP_LOOKUP, OP_DELETE: begin
            cursor_set_nxt = enc_found;
            cursor_nxt     = enc_found ? enc_hit : '0;
            if (enc_found) begin
              res_data.status     = 1'b0;
              res_data.slot_index = SLOT_W'(enc_hit);
              if (op_r.op == OP_DELETE) begin
                valid_nxt[enc_hit] = 1'b0;
              end
            end
          end
          OP_FIRST, OP_NEXT: begin
            if (enc_found) begin
              cursor_set_nxt = 1'b1;
              cursor_nxt     = enc_hit;
            end
          end
          default: ;
        endcase
        if (enc_report) begin
          ram_re = 1'b1;
        end else begin
          res_push = 1'b1;
        end
      end
      B_RD: begin
        res_push               = 1'b1;
        res_data.status        = 1'b0;
        res_data.slot_index    = SLOT_W'(hit_r);
        res_data.found_key     = keys_r[hit_r];
        res_data.found_payload = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      valid_r      <= '0;
      cursor_set_r <= 1'b0;
      cursor_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      cursor_set_r <= cursor_set_nxt;
      cursor_r     <= cursor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    sel_r <= sel_nxt;
    dup_r <= dup_nxt;
    hit_r <= hit_nxt;
    if (key_we) begin
      keys_r[enc_hit] <= op_r.key;
    end
  end

  kst_ram #(
    .WIDTH (PAY_W),
    .DEPTH (ENTRIES)
  ) u_pay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (enc_hit),
    .wdata (op_r.pay),
    .re    (ram_re),
    .raddr (enc_hit),
    .rdata (ram_rdata)
  );

endmodule

>>> design/keyed_slot_table_with_cursor.sv
// Add, delete and failed requests finish after key compare and priority encode;
//   successful lookup, first and next also read the payload RAM.
// The table sequencer (key compare, priority encode, payload read) works on
//   one request at a time and takes the next after pushing the last result.
// Reset: synchronous; clears slot valid marks, cursor and both queues.
//   Keys and payloads are not cleared.
// ----------------------------------------------------------------------------
// keyed_slot_table_with_cursor: keyed slot table with iteration cursor
// Front decodes and queues requests; back executes them on the slot table.
// ----------------------------------------------------------------------------
module keyed_slot_table_with_cursor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  kst_pkg::in_t  in_data,
  output logic          empty,
  input  logic          pop,
  output kst_pkg::out_t out_data
);
  import kst_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd_data;
  logic res_room;
  logic res_push;
  out_t res_data;

  kst_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data)
  );

  kst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd_data  (cmd_data),
    .res_room  (res_room),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  kst_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .res_push (res_push),
    .res_data (res_data),
    .res_room (res_room),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

>>> design/kst_chk.sv
// ----------------------------------------------------------------------------
// kst_chk: port-level checks for the keyed slot table
// Tracks outstanding requests and checks result and queue behaviour.
// ----------------------------------------------------------------------------
module kst_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          push,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input kst_pkg::out_t out_data
);
  import kst_pkg::*;

  logic [3:0] pending_r, pending_nxt;
  logic       in_ok;
  logic       out_ok;

  assign in_ok  = push && !full;
  assign out_ok = pop && !empty;

  always_comb begin
    pending_nxt = pending_r + {3'd0, in_ok} - {3'd0, out_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 4'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  a_reset_clear: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not cleared by reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r == 4'd0) |-> empty)
    else $error("result without outstanding request");

  a_no_early_full: assert property (@(posedge clk) disable iff (!rst_n)
    (pending_r < 4'd2) |-> !full)
    else $error("full with fewer than two requests outstanding");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status) |->
      ((out_data.slot_index == '0) && (out_data.found_key == '0) &&
       (out_data.found_payload == '0)))
    else $error("failed result carries non-zero fields");

endmodule

bind keyed_slot_table_with_cursor kst_chk u_chk (.*);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: keyed slot table with cursor
// Requests go in through the push queue with random gaps. Results are popped
// with random stalls and checked field by field against a local copy of the
// slot table and cursor, kept in step on every accepted request.
// ----------------------------------------------------------------------------
module testbench;
  import kst_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 525;
  localparam int SETTLE      = 20;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_LEN    = 300;
  localparam int KEY_POOL    = 40;
  localparam int MAX_LINES   = 40;
  localparam int NO_SLOT     = -1;

  localparam logic [REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_MID = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI  = 3'd7;
  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;
  localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_WALK, MIX_ANY} mix_t;

  typedef struct {
    in_t req;
    bit  drain_first;
  } job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  in_t  in_data = '0;
  logic full;
  logic empty;
  out_t out_data;

  keyed_slot_table_with_cursor u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // local copy of the table
  logic                    tbl_valid [ENTRIES];
  logic signed [KEY_W-1:0] tbl_key [ENTRIES];
  logic [PAY_W-1:0]        tbl_pay [ENTRIES];
  logic                    cur_set;
  int                      cur_slot;

  job_t req_q [$];
  out_t due_q [$];

  int n_acc = 0;
  int n_got = 0;
  int n_bad = 0;
  logic [31:0] cyc = '0;
  logic calm;

  assign calm = (cyc[10:9] == 2'b00);

  function automatic int scan_table(int from, bit by_key, logic signed [KEY_W-1:0] k);
    for (int i = from; i < ENTRIES; i++)
      if (tbl_valid[i] && (!by_key || tbl_key[i] == k)) return i;
    return NO_SLOT;
  endfunction

  function automatic out_t table_apply(in_t r);
    out_t res;
    int   hit;
    int   start;
    bit   show;
    res  = '0;
    hit  = NO_SLOT;
    show = 1'b0;
    case (r.req_type)
      REQ_ADD: begin
        if (scan_table(0, 1'b1, r.key) == NO_SLOT) begin
          for (int i = 0; i < ENTRIES && hit == NO_SLOT; i++)
            if (!tbl_valid[i]) hit = i;
          if (hit != NO_SLOT) begin
            tbl_valid[hit] = 1'b1;
            tbl_key[hit]   = r.key;
            tbl_pay[hit]   = r.payload_handle;
          end
        end
      end
      REQ_LOOKUP, REQ_DELETE: begin
        cur_set  = 1'b0;
        cur_slot = 0;
        hit = scan_table(0, 1'b1, r.key);
        if (hit != NO_SLOT) begin
          cur_set  = 1'b1;
          cur_slot = hit;
          if (r.req_type == REQ_DELETE) tbl_valid[hit] = 1'b0;
          else show = 1'b1;
        end
      end
      REQ_FIRST, REQ_NEXT: begin
        start = (r.req_type == REQ_NEXT && cur_set) ? cur_slot + 1 : 0;
        hit = scan_table(start, 1'b0, '0);
        if (hit != NO_SLOT) begin
          cur_set  = 1'b1;
          cur_slot = hit;
          show     = 1'b1;
        end
      end
      default: ;
    endcase
    if (hit == NO_SLOT) begin
      res.status = ST_FAIL;
    end else begin
      res.status     = ST_OK;
      res.slot_index = hit[SLOT_W-1:0];
      if (show) begin
        res.found_key     = tbl_key[hit];
        res.found_payload = tbl_pay[hit];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (n_bad < MAX_LINES) $display("MISMATCH at %0t: %s", $time, msg);
    n_bad++;
  endtask

  task automatic check_result(out_t got);
    out_t want;
    if (due_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing outstanding: %h", got));
      return;
    end
    want = due_q.pop_front();
    if (got.status !== want.status)
      report_mismatch($sformatf("status %b, want %b", got.status, want.status));
    if (got.slot_index !== want.slot_index)
      report_mismatch($sformatf("slot_index %0d, want %0d", got.slot_index, want.slot_index));
    if (got.found_key !== want.found_key)
      report_mismatch($sformatf("found_key %h, want %h", got.found_key, want.found_key));
    if (got.found_payload !== want.found_payload)
      report_mismatch($sformatf("found_payload %h, want %h",
                                got.found_payload, want.found_payload));
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap(bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_req(logic [REQ_W-1:0] op, logic signed [KEY_W-1:0] k,
                           logic [PAY_W-1:0] p, bit drain = 1'b0);
    job_t j;
    j.req.req_type       = op;
    j.req.key            = k;
    j.req.payload_handle = p;
    j.drain_first        = drain;
    req_q.push_back(j);
  endtask

  // request driver
  int gap_left = 0;

  always @(posedge clk) begin
    bit   took;
    bit   nxt_push;
    job_t job;
    if (rst_n) begin
      took = push && !full;
      if (took) due_q.push_back(table_apply(in_data));
      n_acc <= n_acc + int'(took);
      nxt_push = push && !took;
      if (!nxt_push) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (req_q.size() > 0 &&
                     (!req_q[0].drain_first || n_acc + int'(took) == n_got)) begin
          job = req_q.pop_front();
          in_data  <= job.req;
          nxt_push = 1'b1;
          gap_left <= pick_gap(calm);
        end
      end
      push <= nxt_push;
    end
  end

  // result monitor
  int hold_left = 0;
  int stall_left = 0;
  bit held_once = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) begin
        check_result(out_data);
        n_got <= n_got + 1;
      end
      if (!held_once && n_acc >= HOLD_AT) begin
        held_once <= 1'b1;
        hold_left <= HOLD_LEN;
        pop <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left <= pick_gap(calm);
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    logic signed [KEY_W-1:0] pool [KEY_POOL];
    logic [REQ_W-1:0]        ops [5];
    int                      mix [4][5];
    logic [REQ_W-1:0]        op;
    logic signed [KEY_W-1:0] k;
    int                      made;
    int                      len;
    int                      roll;
    mix_t                    mode;

    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    cur_set  = 1'b0;
    cur_slot = 0;

    ops = '{REQ_ADD, REQ_LOOKUP, REQ_DELETE, REQ_FIRST, REQ_NEXT};
    // cumulative percentages: add, lookup, delete, first, next; rest is spare codes
    mix[MIX_FILL]  = '{70, 80, 88, 91, 97};
    mix[MIX_DRAIN] = '{12, 22, 82, 85, 97};
    mix[MIX_WALK]  = '{8, 16, 22, 38, 97};
    mix[MIX_ANY]   = '{20, 40, 60, 75, 94};

    pool[0] = KEY_MIN;
    pool[1] = KEY_MAX;
    pool[2] = '0;
    pool[3] = '1;
    for (int i = 4; i < KEY_POOL; i++) pool[i] = $urandom;

    // directed: empty table, extremes, duplicate, cursor moves, spare codes
    queue_req(REQ_NEXT, '0, '0);
    queue_req(REQ_FIRST, '0, '0);
    queue_req(REQ_LOOKUP, '0, '0);
    queue_req(REQ_DELETE, KEY_MIN, '0);
    queue_req(REQ_ADD, KEY_MIN, '0);
    queue_req(REQ_ADD, KEY_MAX, '1);
    queue_req(REQ_ADD, '0, 16'h1234);
    queue_req(REQ_ADD, '1, 16'ha5a5);
    queue_req(REQ_ADD, KEY_MAX, 16'h0f0f);
    queue_req(REQ_LOOKUP, '1, '0);
    queue_req(REQ_NEXT, '0, '0);
    queue_req(REQ_FIRST, '0, '0);
    queue_req(REQ_NEXT, '0, '0);
    queue_req(REQ_DELETE, KEY_MAX, '0);
    queue_req(REQ_NEXT, '0, '0);
    queue_req(REQ_LOOKUP, 32'sd5, '0);
    queue_req(REQ_NEXT, '0, '0);
    queue_req(REQ_SPARE_LO, KEY_MAX, '1);
    queue_req(REQ_SPARE_MID, '1, 16'h5a5a);
    queue_req(REQ_SPARE_HI, KEY_MIN, '0);
    queue_req(REQ_ADD, 32'sd5, 16'h0005);
    queue_req(REQ_DELETE, '0, '0, 1'b1);
    queue_req(REQ_ADD, 32'sh5555_5555, 16'h5555);
    queue_req(REQ_ADD, 32'shaaaa_aaaa, 16'haaaa);
    queue_req(REQ_LOOKUP, 32'shaaaa_aaaa, '0);

    // random bursts, each biased to fill, drain, walk or mix
    made = 0;
    while (made < RANDOM_REQS) begin
      mode = mix_t'($urandom_range(MIX_FILL, MIX_ANY));
      len  = $urandom_range(10, 50);
      for (int j = 0; j < len; j++) begin
        roll = $urandom_range(0, 99);
        op = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
        for (int q = 4; q >= 0; q--)
          if (roll < mix[mode][q]) op = ops[q];
        if (mode == MIX_WALK && j == 0) op = REQ_FIRST;
        k = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, KEY_POOL-1)]
                                         : KEY_W'($urandom);
        queue_req(op, k, PAY_W'($urandom), j == 0 && $urandom_range(0, 3) == 0);
      end
      made += len;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (req_q.size() > 0 || push || n_got != n_acc) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (due_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_q.size()));
    if (n_bad == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

>>> keyed_slot_table_with_cursor.f
design/kst_pkg.sv
design/kst_ram.sv
design/kst_front.sv
design/kst_outq.sv
design/kst_back.sv
design/keyed_slot_table_with_cursor.sv
design/kst_chk.sv
verif/testbench.sv
